// ===== src/obst_pkg.sv =====
package obst_pkg;

  localparam int KEY_W  = 4;
  localparam int PROB_W = 16;
  localparam int COST_W = 23;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic             load;         // store prob_i at key index k (0-based)
    logic             k_issue;      // read subranges for root k, add p_k to the weight
    logic             k_eval;       // compare candidate for root k
    logic             range_write;  // store cost and root of range i..j
    logic             out_issue;    // read cost and root of range i..j for output
    logic [KEY_W-1:0] i;
    logic [KEY_W-1:0] j;
    logic [KEY_W-1:0] k;
  } obst_cmd_t;

endpackage

// ===== src/obst_ram.sv =====
module obst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/obst_datapath.sv =====
module obst_datapath
  import obst_pkg::*;
#(
  parameter int MAX_KEYS = 8
) (
  input  logic              clk_i,
  input  obst_cmd_t         cmd_i,
  input  logic [PROB_W-1:0] prob_i,
  output logic [COST_W-1:0] cost_o,
  output logic [KEY_W-1:0]  root_o
);

  localparam int PW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int DEPTH = MAX_KEYS * MAX_KEYS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W = PROB_W + $clog2(MAX_KEYS + 1);

  logic [PROB_W-1:0] prob_q [MAX_KEYS];
  logic [KEY_W-1:0]  km1, kp1;
  logic [PROB_W-1:0] pk;
  logic [SUM_W-1:0]  w_q, w_d;
  logic [COST_W:0]   best_q, best_d, cand, total;
  logic [KEY_W-1:0]  root_q, root_d, kk_q;
  logic              left_empty_q, right_empty_q, first_q;
  logic [AW-1:0]     addr_ij, addr_left, addr_right, raddr_a;
  logic [COST_W-1:0] rd_a, rd_b, wr_cost;

  // Row-major cell of range r..c, both 1-based
  function automatic logic [AW-1:0] cell_addr(logic [KEY_W-1:0] r, logic [KEY_W-1:0] c);
    return AW'((int'(r) - 1) * MAX_KEYS + int'(c) - 1);
  endfunction

  assign km1        = cmd_i.k - KEY_W'(1);
  assign kp1        = cmd_i.k + KEY_W'(1);
  assign pk         = prob_q[km1[PW-1:0]];
  assign addr_ij    = cell_addr(cmd_i.i, cmd_i.j);
  assign addr_left  = cell_addr(cmd_i.i, km1);
  assign addr_right = cell_addr(kp1, cmd_i.j);
  assign raddr_a    = cmd_i.out_issue ? addr_ij : addr_left;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      prob_q[cmd_i.k[PW-1:0]] <= prob_i;
    end
  end

  // Weight grows by one key per root step, so it is complete after the last root
  always_comb begin
    w_d = w_q;
    if (cmd_i.k_issue) begin
      if (cmd_i.k == cmd_i.i) begin
        w_d = SUM_W'(pk);
      end else begin
        w_d = w_q + SUM_W'(pk);
      end
    end
  end

  // Empty subranges cost nothing; the weight is common to all roots, add it at the end
  assign cand = (left_empty_q  ? '0 : {1'b0, rd_a}) +
                (right_empty_q ? '0 : {1'b0, rd_b});

  always_comb begin
    best_d = best_q;
    root_d = root_q;
    if (cmd_i.k_eval && (first_q || best_q >= cand)) begin
      best_d = cand;
      root_d = kk_q;
    end
  end

  assign total   = best_q + (COST_W + 1)'(w_q);
  assign wr_cost = total[COST_W-1:0];

  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    best_q <= best_d;
    root_q <= root_d;
    if (cmd_i.k_issue) begin
      left_empty_q  <= (cmd_i.k == cmd_i.i);
      right_empty_q <= (cmd_i.k == cmd_i.j);
      first_q       <= (cmd_i.k == cmd_i.i);
      kk_q          <= cmd_i.k;
    end
  end

  obst_ram #(.WIDTH(COST_W), .DEPTH(DEPTH), .AW(AW)) u_cost_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.range_write),
    .waddr_i (addr_ij),
    .wdata_i (wr_cost),
    .raddr_i (raddr_a),
    .rdata_o (rd_a)
  );

  // Mirror of the cost table for the second read per step
  obst_ram #(.WIDTH(COST_W), .DEPTH(DEPTH), .AW(AW)) u_cost_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.range_write),
    .waddr_i (addr_ij),
    .wdata_i (wr_cost),
    .raddr_i (addr_right),
    .rdata_o (rd_b)
  );

  obst_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH), .AW(AW)) u_root (
    .clk_i   (clk_i),
    .we_i    (cmd_i.range_write),
    .waddr_i (addr_ij),
    .wdata_i (root_q),
    .raddr_i (addr_ij),
    .rdata_o (root_o)
  );

  assign cost_o = rd_a;

endmodule

// ===== src/obst_ctrl.sv =====
module obst_ctrl
  import obst_pkg::*;
#(
  parameter int MAX_KEYS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             last_key_i,
  output obst_cmd_t        cmd_o,
  output logic             busy_o,
  output logic             res_valid_o,
  output logic [KEY_W-1:0] row_i_o,
  output logic [KEY_W-1:0] col_j_o,
  output logic             last_o,
  output logic             overflow_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ISSUE  = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_WRITE  = 3'd3;
  localparam logic [2:0] S_OISSUE = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  localparam logic [KEY_W-1:0] MaxK = KEY_W'(MAX_KEYS);
  localparam logic [KEY_W-1:0] One  = KEY_W'(1);

  logic [2:0]       state_q, state_d;
  logic [KEY_W-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d, k_q, k_d;
  logic             ovf_q, ovf_d;
  logic [KEY_W-1:0] span;

  assign span = j_q - i_q + One;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.i = i_q;
    cmd_o.j = j_q;
    cmd_o.k = k_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.k = cnt_q;
        if (start_i) begin
          if (cnt_q < MaxK) begin
            cmd_o.load = 1'b1;
            cnt_d      = cnt_q + One;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_key_i) begin
            i_d     = One;
            j_d     = One;
            k_d     = One;
            state_d = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        cmd_o.k_issue = 1'b1;
        state_d       = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.k_eval = 1'b1;
        if (k_q == j_q) begin
          state_d = S_WRITE;
        end else begin
          k_d     = k_q + One;
          state_d = S_ISSUE;
        end
      end
      S_WRITE: begin
        cmd_o.range_write = 1'b1;
        if (j_q != cnt_q) begin
          // slide along the current diagonal
          i_d     = i_q + One;
          j_d     = j_q + One;
          k_d     = i_q + One;
          state_d = S_ISSUE;
        end else if (span < cnt_q) begin
          // next longer range length
          i_d     = One;
          j_d     = span + One;
          k_d     = One;
          state_d = S_ISSUE;
        end else begin
          i_d     = One;
          j_d     = One;
          state_d = S_OISSUE;
        end
      end
      S_OISSUE: begin
        cmd_o.out_issue = 1'b1;
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        if (j_q == cnt_q) begin
          if (i_q == cnt_q) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + One;
            j_d     = i_q + One;
            state_d = S_OISSUE;
          end
        end else begin
          j_d     = j_q + One;
          state_d = S_OISSUE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_EMIT);
  assign row_i_o     = i_q;
  assign col_j_o     = j_q;
  assign last_o      = (state_q == S_EMIT) && (i_q == cnt_q) && (j_q == cnt_q);
  assign overflow_o  = ovf_q;

endmodule

// ===== src/optimal_bst_cost_table.sv =====
// Loading: one key per cycle, busy_o stays low; no results.
// Run (n keys): the table fills range by range, shortest ranges first; each root
//   candidate takes an issue and an evaluate step, each range one write step; then
//   n(n+1)/2 results follow, each from an output issue and an emit step.
// Results appear for one cycle on res_valid_o; the receiver cannot stall.
// rst_ni (async, active low) clears the key count, overflow flag and sequencer.
module optimal_bst_cost_table
  import obst_pkg::*;
#(
  parameter int MAX_KEYS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [PROB_W-1:0] prob_i,
  input  logic              last_key_i,
  output logic              res_valid_o,
  output logic [KEY_W-1:0]  row_i_o,
  output logic [KEY_W-1:0]  col_j_o,
  output logic [COST_W-1:0] cost_o,
  output logic [KEY_W-1:0]  root_o,
  output logic              last_o,
  output logic              overflow_o
);

  obst_cmd_t cmd;

  obst_ctrl #(.MAX_KEYS(MAX_KEYS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .last_key_i  (last_key_i),
    .cmd_o       (cmd),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .row_i_o     (row_i_o),
    .col_j_o     (col_j_o),
    .last_o      (last_o),
    .overflow_o  (overflow_o)
  );

  obst_datapath #(.MAX_KEYS(MAX_KEYS)) u_dp (
    .clk_i  (clk_i),
    .cmd_i  (cmd),
    .prob_i (prob_i),
    .cost_o (cost_o),
    .root_o (root_o)
  );

endmodule

// ===== src/obst_checker.sv =====
module obst_checker
  import obst_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              last_key_i,
  input logic              res_valid_o,
  input logic [KEY_W-1:0]  row_i_o,
  input logic [KEY_W-1:0]  col_j_o,
  input logic [KEY_W-1:0]  root_o,
  input logic              last_o
);

  // results only come out during a run
  a_result_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy_o)
    else $error("result strobe while idle");

  // a loading item never starts a run
  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !last_key_i) |=> !busy_o)
    else $error("busy after a loading item");

  // the final key starts a run
  a_last_key_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_key_i) |=> busy_o)
    else $error("final key did not start a run");

  // the run ends right after its last result
  a_end_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && last_o) |=> !busy_o)
    else $error("still busy after last result");

  // every range is well formed and its root lies inside it
  a_range_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (row_i_o != '0) && (row_i_o <= col_j_o) &&
                    (root_o >= row_i_o) && (root_o <= col_j_o))
    else $error("bad range or root");

endmodule

bind optimal_bst_cost_table obst_checker u_obst_checker (.*);

// ===== verif/bst_cost_checker_pkg.sv =====
package bst_cost_checker_pkg;

  import obst_pkg::*;

  typedef struct {
    logic [KEY_W-1:0]  row;
    logic [KEY_W-1:0]  col;
    logic [COST_W-1:0] cost;
    logic [KEY_W-1:0]  root;
    logic              last;
    logic              overflow;
  } range_entry_t;

  class bst_cost_checker #(int NKEYS = 8);

    logic [PROB_W-1:0] key_probs[NKEYS];
    int unsigned       keys_held;
    bit                keys_dropped;
    range_entry_t      pending_ranges[$];
    int unsigned       errors;

    function new();
      keys_held    = 0;
      keys_dropped = 0;
      errors       = 0;
    endfunction

    function int unsigned pending();
      return pending_ranges.size();
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Fill the cost and root tables of the held set and queue one entry per range.
    function void solve_ranges();
      int unsigned  cost_tab[NKEYS+2][NKEYS+2];
      int unsigned  root_tab[NKEYS+2][NKEYS+2];
      int unsigned  n;
      int unsigned  i;
      int unsigned  j;
      int unsigned  k;
      int unsigned  d;
      int unsigned  weight;
      int unsigned  best;
      int unsigned  cand;
      range_entry_t entry;
      n = keys_held;
      for (i = 1; i <= n + 1; i++) begin
        cost_tab[i][i-1] = 0;
        root_tab[i][i-1] = 0;
      end
      for (i = 1; i <= n; i++) begin
        cost_tab[i][i] = key_probs[i-1];
        root_tab[i][i] = i;
      end
      for (d = 1; d < n; d++) begin
        for (i = 1; i + d <= n; i++) begin
          j = i + d;
          weight = 0;
          for (k = i; k <= j; k++) begin
            weight += key_probs[k-1];
          end
          best = cost_tab[i][i-1] + cost_tab[i+1][j] + weight;
          root_tab[i][j] = i;
          // greater-or-equal: the largest minimizing root wins a tie
          for (k = i; k <= j; k++) begin
            cand = cost_tab[i][k-1] + cost_tab[k+1][j] + weight;
            if (best >= cand) begin
              best = cand;
              root_tab[i][j] = k;
            end
          end
          cost_tab[i][j] = best;
        end
      end
      for (i = 1; i <= n; i++) begin
        for (j = i; j <= n; j++) begin
          entry.row      = i[KEY_W-1:0];
          entry.col      = j[KEY_W-1:0];
          entry.cost     = cost_tab[i][j][COST_W-1:0];
          entry.root     = root_tab[i][j][KEY_W-1:0];
          entry.last     = (i == n) && (j == n);
          entry.overflow = keys_dropped;
          pending_ranges.push_back(entry);
        end
      end
    endfunction

    function void note_key(logic [PROB_W-1:0] prob, logic last_key);
      if (keys_held < NKEYS) begin
        key_probs[keys_held] = prob;
        keys_held++;
      end else begin
        keys_dropped = 1'b1;
      end
      if (last_key) begin
        solve_ranges();
        keys_held    = 0;
        keys_dropped = 1'b0;
      end
    endfunction

    task check_field(string name, range_entry_t want, int unsigned got_v, int unsigned want_v);
      if (got_v != want_v) begin
        report($sformatf("range %0d..%0d %s got %0d want %0d",
                         want.row, want.col, name, got_v, want_v));
      end
    endtask

    task check_range(logic [KEY_W-1:0] row, logic [KEY_W-1:0] col, logic [COST_W-1:0] cost,
                     logic [KEY_W-1:0] root, logic last, logic overflow);
      range_entry_t want;
      if (pending_ranges.size() == 0) begin
        report($sformatf("unexpected result range %0d..%0d cost %0d", row, col, cost));
        return;
      end
      want = pending_ranges.pop_front();
      check_field("row", want, row, want.row);
      check_field("col", want, col, want.col);
      check_field("cost", want, cost, want.cost);
      check_field("root", want, root, want.root);
      check_field("last", want, last, want.last);
      check_field("overflow", want, overflow, want.overflow);
    endtask

  endclass

endpackage

// ===== verif/tb_top.sv =====
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import obst_pkg::*;
  import bst_cost_checker_pkg::*;

  localparam int MaxKeys     = 8;
  localparam int RandomItems = 360;
  localparam int DrainCycles = 400;

  typedef bst_cost_checker_pkg::bst_cost_checker #(MaxKeys) scoreboard_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [PROB_W-1:0] prob_i;
  logic              last_key_i;
  logic              res_valid_o;
  logic [KEY_W-1:0]  row_i_o;
  logic [KEY_W-1:0]  col_j_o;
  logic [COST_W-1:0] cost_o;
  logic [KEY_W-1:0]  root_o;
  logic              last_o;
  logic              overflow_o;

  scoreboard_t ranges = new();
  int unsigned items_sent;

  optimal_bst_cost_table #(
    .MAX_KEYS(MaxKeys)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .prob_i     (prob_i),
    .last_key_i (last_key_i),
    .res_valid_o(res_valid_o),
    .row_i_o    (row_i_o),
    .col_j_o    (col_j_o),
    .cost_o     (cost_o),
    .root_o     (root_o),
    .last_o     (last_o),
    .overflow_o (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sample both handshakes at the rising edge, before the block updates.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) begin
        ranges.check_range(row_i_o, col_j_o, cost_o, root_o, last_o, overflow_o);
      end
      if (start_i && !busy_o) begin
        ranges.note_key(prob_i, last_key_i);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_key(logic [PROB_W-1:0] prob, logic last_key, int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i    = 1'b0;
      prob_i     = PROB_W'($urandom);
      last_key_i = 1'($urandom);
      @(negedge clk_i);
    end
    start_i    = 1'b1;
    prob_i     = prob;
    last_key_i = last_key;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_uniform_set(int unsigned n, logic [PROB_W-1:0] prob);
    for (int unsigned t = 0; t < n; t++) begin
      send_key(prob, t == n - 1, 0);
    end
  endtask

  task automatic send_random_set(int unsigned idle_pct);
    int unsigned       n;
    logic [PROB_W-1:0] prob;
    n = ($urandom_range(99) < 12) ? $urandom_range(12, MaxKeys + 1) : $urandom_range(MaxKeys, 1);
    prob = PROB_W'($urandom);
    for (int unsigned t = 0; t < n; t++) begin
      // mix in extremes and repeats to provoke ties
      case ($urandom_range(9))
        0:       prob = '0;
        1:       prob = '1;
        2:       prob = PROB_W'($urandom_range(3));
        3:       prob = prob;
        default: prob = PROB_W'($urandom);
      endcase
      send_key(prob, t == n - 1, idle_pct);
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    prob_i     = '0;
    last_key_i = 1'b0;
    items_sent = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_uniform_set(1, '0);
    send_uniform_set(1, '1);
    // one key past capacity, dropped on the last item itself
    send_uniform_set(MaxKeys + 1, '1);
    send_uniform_set(4, '0);
    send_uniform_set(3, 16'h8000);
    for (int unsigned t = 0; t < MaxKeys; t++) begin
      send_key(PROB_W'(16'h0101 + t * 16'h1f3d), t == MaxKeys - 1, 0);
    end

    items_sent = 0;
    while (items_sent < RandomItems / 3) send_random_set(19);
    while (items_sent < 2 * RandomItems / 3) send_random_set(47);
    while (items_sent < RandomItems) send_random_set(0);

    start_i = 1'b0;
    while (ranges.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (ranges.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== optimal_bst_cost_table.f =====
src/obst_pkg.sv
src/obst_ram.sv
src/obst_datapath.sv
src/obst_ctrl.sv
src/optimal_bst_cost_table.sv
src/obst_checker.sv
verif/bst_cost_checker_pkg.sv
verif/tb_top.sv
